// File: hdl/trmq_pkg.sv
// ----------------------------------------------------------------------------
// trmq_pkg: shared types and constants of the timed release message queue
// Result codes, engine states, field widths and the configuration bundle.
// ----------------------------------------------------------------------------
package trmq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_TIME_WIDTH  = 32;
  localparam int HANDLE_W        = 16;
  localparam int LIMIT_W         = 5;
  localparam int COUNT_OUT_W     = 5;
  localparam int RKIND_W         = 3;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 5;
  localparam int CMD_FIFO_DEPTH  = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SORTED_MODE  = 2'd2;

  // input word kinds
  localparam logic KIND_ARRIVAL = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  typedef enum logic [RKIND_W-1:0] {
    RK_ACCEPTED  = 3'd0,
    RK_DROPPED   = 3'd1,
    RK_REJECTED  = 3'd2,
    RK_DELIVERED = 3'd3,
    RK_TICK_DONE = 3'd4
  } rkind_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DROP = 2'd1,
    ST_POP  = 2'd2
  } eng_state_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] queue_limit;
    logic               limit_enable;
    logic               sorted_mode;
  } cfg_t;

endpackage

// File: hdl/trmq_if.sv
// ----------------------------------------------------------------------------
// trmq_if: channel interfaces of the timed release message queue
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface trmq_in_if
  import trmq_pkg::*;
#(
  parameter int TIME_WIDTH = DEF_TIME_WIDTH
) ();
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [HANDLE_W-1:0]   msg_handle;
  logic [TIME_WIDTH-1:0] time_stamp;

  modport source (output valid, kind, msg_handle, time_stamp, input ready);
  modport sink   (input valid, kind, msg_handle, time_stamp, output ready);
endinterface

interface trmq_out_if
  import trmq_pkg::*;
#(
  parameter int TIME_WIDTH = DEF_TIME_WIDTH
) ();
  logic                   valid;
  logic                   ready;
  logic [RKIND_W-1:0]     result_kind;
  logic [HANDLE_W-1:0]    out_handle;
  logic [TIME_WIDTH-1:0]  out_time;
  logic [COUNT_OUT_W-1:0] delivered_count;
  logic                   last;

  modport source (output valid, result_kind, out_handle, out_time, delivered_count, last,
                  input ready);
  modport sink   (input valid, result_kind, out_handle, out_time, delivered_count, last,
                  output ready);
endinterface

// File: hdl/trmq_cmd_fifo.sv
// ----------------------------------------------------------------------------
// trmq_cmd_fifo: front end command queue
// Accepts input words and holds them until the engine takes them.
// ----------------------------------------------------------------------------
module trmq_cmd_fifo
  import trmq_pkg::*;
#(
  parameter int TIME_WIDTH = DEF_TIME_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  logic [HANDLE_W-1:0]   in_handle,
  input  logic [TIME_WIDTH-1:0] in_time,
  output logic                  cmd_valid,
  input  logic                  cmd_take,
  output logic                  cmd_kind,
  output logic [HANDLE_W-1:0]   cmd_handle,
  output logic [TIME_WIDTH-1:0] cmd_time
);

  localparam int PW = $clog2(CMD_FIFO_DEPTH);
  localparam int CW = $clog2(CMD_FIFO_DEPTH + 1);

  logic                  kind_r [CMD_FIFO_DEPTH];
  logic [HANDLE_W-1:0]   hdl_r  [CMD_FIFO_DEPTH];
  logic [TIME_WIDTH-1:0] time_r [CMD_FIFO_DEPTH];
  logic [PW-1:0]         wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]         fill_r, fill_nxt;
  logic                  push, pop;

  assign in_ready  = (fill_r != CW'(CMD_FIFO_DEPTH));
  assign cmd_valid = (fill_r != '0);
  assign push      = in_valid && in_ready;
  assign pop       = cmd_take && cmd_valid;

  assign cmd_kind   = kind_r[rd_ptr_r];
  assign cmd_handle = hdl_r[rd_ptr_r];
  assign cmd_time   = time_r[rd_ptr_r];

  // advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    fill_nxt = fill_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // store the word
  always_ff @(posedge clk) begin
    if (push) begin
      kind_r[wr_ptr_r] <= in_kind;
      hdl_r[wr_ptr_r]  <= in_handle;
      time_r[wr_ptr_r] <= in_time;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(CMD_FIFO_DEPTH))
    else $error("command fifo overfilled");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == '0) |-> !pop)
    else $error("pop from empty command fifo");
  a_fill_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (fill_r == $past(fill_r) + 1'b1))
    else $error("fill level lost a push");

endmodule

// File: hdl/trmq_engine.sv
// ----------------------------------------------------------------------------
// trmq_engine: back end of the timed release message queue
// Keeps the pending store, inserts or rejects arrivals, trims, and releases on ticks.
// ----------------------------------------------------------------------------
module trmq_engine
  import trmq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int TIME_WIDTH  = DEF_TIME_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  cmd_valid,
  output logic                  cmd_take,
  input  logic                  cmd_kind,
  input  logic [HANDLE_W-1:0]   cmd_handle,
  input  logic [TIME_WIDTH-1:0] cmd_time,
  trmq_out_if.source            out_word
);

  localparam int CW = $clog2(QUEUE_DEPTH + 2);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int SD = QUEUE_DEPTH + 1;

  // store has one spare slot for an insert into a full store before the trim
  logic [TIME_WIDTH-1:0] time_r [SD];
  logic [HANDLE_W-1:0]   hdl_r  [SD];
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         drop_left_r, drop_left_nxt;
  logic [CW-1:0]         popped_r, popped_nxt;
  logic [TIME_WIDTH-1:0] cur_time_r;
  eng_state_t            state_r, state_nxt;

  logic                  out_valid_r;
  rkind_t                out_kind_r;
  logic [HANDLE_W-1:0]   out_hdl_r;
  logic [TIME_WIDTH-1:0] out_time_r;
  logic [COUNT_OUT_W-1:0] out_cnt_r;
  logic                  out_last_r;

  logic                  out_ok;
  logic [CW-1:0]         pos;
  logic [CW-1:0]         total;
  logic [LW-1:0]         lim;
  logic [CW-1:0]         drop;
  logic                  full_reject;
  logic                  do_insert, do_shift, do_emit, latch_tick;
  rkind_t                emit_kind;
  logic [HANDLE_W-1:0]   emit_hdl;
  logic [TIME_WIDTH-1:0] emit_time;
  logic [COUNT_OUT_W-1:0] emit_cnt;
  logic                  emit_last;
  logic                  pop_hit;

  assign out_ok = !out_valid_r || out_word.ready;

  // find the insert slot: at the end in append mode, else after the last entry not later than the arrival
  always_comb begin
    pos = cnt_r;
    if (cfg.sorted_mode) begin
      pos = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if ((CW'(i) < cnt_r) && (time_r[i] <= cmd_time)) pos = CW'(i + 1);
      end
    end
  end

  // trim amount after the insert
  always_comb begin
    total = cnt_r + 1'b1;
    if (cfg.limit_enable) begin
      lim = (LW'(cfg.queue_limit) > LW'(QUEUE_DEPTH)) ? LW'(QUEUE_DEPTH)
                                                       : LW'(cfg.queue_limit);
    end else begin
      lim = LW'(total);
    end
    drop = (LW'(total) > lim) ? CW'(LW'(total) - lim) : '0;
  end

  assign full_reject = !cfg.limit_enable && (cnt_r >= CW'(QUEUE_DEPTH));
  assign pop_hit     = (cnt_r != '0) && (cur_time_r >= time_r[0]);

  // control outputs of the sequencer
  always_comb begin
    cmd_take      = 1'b0;
    do_insert     = 1'b0;
    do_shift      = 1'b0;
    do_emit       = 1'b0;
    latch_tick    = 1'b0;
    emit_kind     = RK_ACCEPTED;
    emit_hdl      = cmd_handle;
    emit_time     = cmd_time;
    emit_cnt      = '0;
    emit_last     = 1'b0;
    cnt_nxt       = cnt_r;
    drop_left_nxt = drop_left_r;
    popped_nxt    = popped_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid && out_ok) begin
          cmd_take = 1'b1;
          if (cmd_kind == KIND_TICK) begin
            latch_tick = 1'b1;
            popped_nxt = '0;
          end else if (full_reject) begin
            do_emit   = 1'b1;
            emit_kind = RK_REJECTED;
            emit_last = 1'b1;
          end else begin
            do_insert     = 1'b1;
            cnt_nxt       = total;
            drop_left_nxt = drop;
            if (pos >= drop) begin
              do_emit   = 1'b1;
              emit_kind = RK_ACCEPTED;
              emit_last = (drop == '0);
            end
          end
        end
      end
      ST_DROP: begin
        if (out_ok) begin
          do_emit       = 1'b1;
          do_shift      = 1'b1;
          emit_kind     = RK_DROPPED;
          emit_hdl      = hdl_r[0];
          emit_time     = time_r[0];
          emit_last     = (drop_left_r == CW'(1));
          cnt_nxt       = cnt_r - 1'b1;
          drop_left_nxt = drop_left_r - 1'b1;
        end
      end
      ST_POP: begin
        if (out_ok) begin
          do_emit = 1'b1;
          if (pop_hit) begin
            do_shift   = 1'b1;
            emit_kind  = RK_DELIVERED;
            emit_hdl   = hdl_r[0];
            emit_time  = time_r[0];
            cnt_nxt    = cnt_r - 1'b1;
            popped_nxt = popped_r + 1'b1;
          end else begin
            emit_kind = RK_TICK_DONE;
            emit_hdl  = '0;
            emit_time = '0;
            emit_cnt  = COUNT_OUT_W'(popped_r);
            emit_last = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_take) begin
          if (latch_tick) state_nxt = ST_POP;
          else if (do_insert && (drop != '0)) state_nxt = ST_DROP;
        end
      end
      ST_DROP: if (do_emit && emit_last) state_nxt = ST_IDLE;
      ST_POP:  if (do_emit && emit_last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      drop_left_r <= '0;
      popped_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      drop_left_r <= drop_left_nxt;
      popped_r    <= popped_nxt;
      if (do_emit) out_valid_r <= 1'b1;
      else if (out_word.ready) out_valid_r <= 1'b0;
    end
  end

  // hold result word and tick time
  always_ff @(posedge clk) begin
    if (do_emit) begin
      out_kind_r <= emit_kind;
      out_hdl_r  <= emit_hdl;
      out_time_r <= emit_time;
      out_cnt_r  <= emit_cnt;
      out_last_r <= emit_last;
    end
    if (latch_tick) cur_time_r <= cmd_time;
  end

  // insert at the slot, or advance the store toward the front
  always_ff @(posedge clk) begin
    for (int i = 0; i < SD; i++) begin
      if (do_insert) begin
        if (CW'(i) == pos) begin
          time_r[i] <= cmd_time;
          hdl_r[i]  <= cmd_handle;
        end else if ((CW'(i) > pos) && (i > 0)) begin
          time_r[i] <= time_r[(i > 0) ? i - 1 : 0];
          hdl_r[i]  <= hdl_r[(i > 0) ? i - 1 : 0];
        end
      end else if (do_shift && (i < SD - 1)) begin
        time_r[i] <= time_r[(i < SD - 1) ? i + 1 : i];
        hdl_r[i]  <= hdl_r[(i < SD - 1) ? i + 1 : i];
      end
    end
  end

  assign out_word.valid           = out_valid_r;
  assign out_word.result_kind     = out_kind_r;
  assign out_word.out_handle      = out_hdl_r;
  assign out_word.out_time        = out_time_r;
  assign out_word.delivered_count = out_cnt_r;
  assign out_word.last            = out_last_r;

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (cnt_r <= CW'(QUEUE_DEPTH)))
    else $error("pending count above depth between words");
  a_drop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DROP) |-> ((cnt_r != '0) && (drop_left_r != '0)))
    else $error("trim with nothing left to drop");
  a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (do_emit && (emit_kind == RK_REJECTED)) |=> (cnt_r == $past(cnt_r)))
    else $error("reject changed the pending count");
  a_no_emit_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_word.ready) |-> !do_emit)
    else $error("result overwritten while stalled");

endmodule

// File: hdl/timed_release_message_queue_unit.sv
// An arrival's first result word is registered in the command queue, then in the engine's
// result register; an arrival trimmed at once leads with its drop word from the drop state,
// and further drops follow one per cycle while the output is not stalled. A tick's first
// word passes the command queue, the tick latch and the pop state before the result register.
// The single sequencer over the pending store takes no new word while trimming or releasing.
// Reset (rst_n low, synchronous): store and command queue empty, limit 16, limit off, append.
// ----------------------------------------------------------------------------
// timed_release_message_queue_unit: delay queue for message handles, time sorted or in arrival order
// Front command queue, back engine with the pending store, config registers.
// ----------------------------------------------------------------------------
module timed_release_message_queue_unit
  import trmq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int TIME_WIDTH  = DEF_TIME_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  trmq_in_if.sink               in_word,
  trmq_out_if.source            out_word
);

  cfg_t                  cfg_r;
  logic                  cmd_valid, cmd_take, cmd_kind;
  logic [HANDLE_W-1:0]   cmd_handle;
  logic [TIME_WIDTH-1:0] cmd_time;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.queue_limit  <= LIMIT_W'(16);
      cfg_r.limit_enable <= 1'b0;
      cfg_r.sorted_mode  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_QUEUE_LIMIT:  cfg_r.queue_limit  <= cfg_data[LIMIT_W-1:0];
        CFG_LIMIT_ENABLE: cfg_r.limit_enable <= cfg_data[0];
        CFG_SORTED_MODE:  cfg_r.sorted_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  trmq_cmd_fifo #(.TIME_WIDTH(TIME_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_word.valid),
    .in_ready   (in_word.ready),
    .in_kind    (in_word.kind),
    .in_handle  (in_word.msg_handle),
    .in_time    (in_word.time_stamp),
    .cmd_valid  (cmd_valid),
    .cmd_take   (cmd_take),
    .cmd_kind   (cmd_kind),
    .cmd_handle (cmd_handle),
    .cmd_time   (cmd_time)
  );

  trmq_engine #(.QUEUE_DEPTH(QUEUE_DEPTH), .TIME_WIDTH(TIME_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd_valid  (cmd_valid),
    .cmd_take   (cmd_take),
    .cmd_kind   (cmd_kind),
    .cmd_handle (cmd_handle),
    .cmd_time   (cmd_time),
    .out_word   (out_word)
  );

endmodule
